FILE: src/cnp_pkg.sv
// ----------------------------------------------------------------------------
// cnp_pkg
// Types, constants and small decode functions shared by the newc cpio
// stream parser modules.
// ----------------------------------------------------------------------------
package cnp_pkg;

  localparam int unsigned POS_W  = 33;
  localparam int unsigned SIZE_W = 32;

  // header layout
  localparam logic [POS_W-1:0] HEADER_LAST = 33'd109;  // 110 header bytes
  localparam logic [POS_W-1:0] FSIZE_FIRST = 33'd54;
  localparam logic [POS_W-1:0] FSIZE_END   = 33'd62;   // 8 hex digits
  localparam logic [POS_W-1:0] NSIZE_FIRST = 33'd94;
  localparam logic [POS_W-1:0] NSIZE_END   = 33'd102;

  // trailer name
  localparam logic [POS_W-1:0] TRAILER_LEN     = 33'd10;
  localparam logic [POS_W-1:0] TRAILER_MIN_M1  = 33'd9;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_DATA,
    PH_END
  } phase_t;

  typedef enum logic [2:0] {
    CLS_HEADER   = 3'd0,
    CLS_NAME     = 3'd1,
    CLS_NAME_PAD = 3'd2,
    CLS_DATA     = 3'd3,
    CLS_DATA_PAD = 3'd4,
    CLS_END      = 3'd5
  } byte_class_t;

  typedef struct packed {
    logic [7:0]        data_out;
    byte_class_t       byte_class;
    logic [POS_W-1:0]  part_offset;
    logic              last_of_part;
    logic              entry_start;
    logic [SIZE_W-1:0] file_len;
    logic [SIZE_W-1:0] name_len;
    logic              is_trailer;
    logic              bad_digit;
    logic              archive_end;
  } cnp_result_t;

  // expected name bytes, TRAILER!!!
  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54;  // T
      4'd1:    c = 8'h52;  // R
      4'd2:    c = 8'h41;  // A
      4'd3:    c = 8'h49;  // I
      4'd4:    c = 8'h4C;  // L
      4'd5:    c = 8'h45;  // E
      4'd6:    c = 8'h52;  // R
      4'd7:    c = 8'h21;  // !
      4'd8:    c = 8'h21;  // !
      4'd9:    c = 8'h21;  // !
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // returns {bad, value}; anything outside 0-9 and A-F reads as zero
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b0, b[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b0, 4'(b[3:0] + 4'd9)};
    end else begin
      r = {1'b1, 4'd0};
    end
    return r;
  endfunction

  // last offset of the name part: header plus name padded to 4
  function automatic logic [POS_W-1:0] name_last(input logic [SIZE_W-1:0] n);
    logic [POS_W-1:0] up;
    up = ({1'b0, n} + 33'd5) & ~33'd3;
    return up - 33'd3;
  endfunction

  // last offset of a nonempty data part padded to 4
  function automatic logic [POS_W-1:0] data_last(input logic [SIZE_W-1:0] n);
    logic [POS_W-1:0] up;
    up = ({1'b0, n} + 33'd3) & ~33'd3;
    return up - 33'd1;
  endfunction

endpackage

FILE: src/cnp_step.sv
// ----------------------------------------------------------------------------
// cnp_step
// Per-byte parser state and classification: tags one byte per step and
// advances the part/entry tracking.
// ----------------------------------------------------------------------------
module cnp_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          byte_in,
  output cnp_pkg::cnp_result_t res
);
  import cnp_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  len_m1_r, len_m1_nxt;
  logic [SIZE_W-1:0] fsize_r, fsize_nxt;
  logic [SIZE_W-1:0] nsize_r, nsize_nxt;
  logic              tmatch_r, tmatch_nxt;
  logic              tseen_r, tseen_nxt;
  logic              bad_r, bad_nxt;

  logic              last;
  logic              start;
  logic              in_fs, in_ns;
  logic [4:0]        hx;
  logic              aend;

  assign last  = (pos_r == len_m1_r);
  assign start = (phase_r == PH_HEADER) && (pos_r == '0);
  assign in_fs = (pos_r >= FSIZE_FIRST) && (pos_r < FSIZE_END);
  assign in_ns = (pos_r >= NSIZE_FIRST) && (pos_r < NSIZE_END);
  assign hx    = hex_val(byte_in);

  // datapath: sizes, flags and the archive end decision
  always_comb begin
    fsize_nxt  = fsize_r;
    nsize_nxt  = nsize_r;
    tmatch_nxt = tmatch_r;
    tseen_nxt  = tseen_r;
    bad_nxt    = bad_r;
    aend       = 1'b0;
    unique case (phase_r)
      PH_HEADER: begin
        if (start) begin
          fsize_nxt  = '0;
          nsize_nxt  = '0;
          tmatch_nxt = 1'b1;
          tseen_nxt  = 1'b0;
          bad_nxt    = 1'b0;
        end
        if (in_fs) begin
          fsize_nxt = {fsize_nxt[SIZE_W-5:0], hx[3:0]};
          bad_nxt   = bad_nxt | hx[4];
        end else if (in_ns) begin
          nsize_nxt = {nsize_nxt[SIZE_W-5:0], hx[3:0]};
          bad_nxt   = bad_nxt | hx[4];
        end
      end
      PH_NAME: begin
        if (pos_r < TRAILER_LEN) begin
          if (byte_in != trailer_char(pos_r[3:0])) tmatch_nxt = 1'b0;
        end else if (pos_r == TRAILER_LEN) begin
          if (byte_in != 8'h00) tmatch_nxt = 1'b0;
        end
        if (last && tmatch_nxt && (len_m1_r >= TRAILER_MIN_M1)) tseen_nxt = 1'b1;
        aend = last && tseen_nxt && (fsize_r == '0);
      end
      PH_DATA: begin
        aend = last && tseen_r;
      end
      PH_END: begin
        aend = 1'b0;
      end
      default: begin
        aend = 1'b0;
      end
    endcase
  end

  // next phase, position and part length
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_m1_nxt = len_m1_r;
    if (phase_r != PH_END) begin
      if (!last) begin
        pos_nxt = pos_r + 33'd1;
      end else begin
        pos_nxt = '0;
        if (aend) begin
          phase_nxt = PH_END;
        end else begin
          unique case (phase_r)
            PH_HEADER: begin
              phase_nxt  = PH_NAME;
              len_m1_nxt = name_last(nsize_nxt);
            end
            PH_NAME: begin
              if (fsize_r != '0) begin
                phase_nxt  = PH_DATA;
                len_m1_nxt = data_last(fsize_r);
              end else begin
                phase_nxt  = PH_HEADER;
                len_m1_nxt = HEADER_LAST;
              end
            end
            default: begin
              phase_nxt  = PH_HEADER;
              len_m1_nxt = HEADER_LAST;
            end
          endcase
        end
      end
    end
  end

  // result of this step
  always_comb begin
    res              = '0;
    res.data_out     = byte_in;
    res.byte_class   = CLS_END;
    if (phase_r != PH_END) begin
      unique case (phase_r)
        PH_HEADER: res.byte_class = CLS_HEADER;
        PH_NAME:   res.byte_class = (pos_r < {1'b0, nsize_r}) ? CLS_NAME : CLS_NAME_PAD;
        default:   res.byte_class = (pos_r < {1'b0, fsize_r}) ? CLS_DATA : CLS_DATA_PAD;
      endcase
      res.part_offset  = pos_r;
      res.last_of_part = last;
      res.entry_start  = start;
      res.file_len     = fsize_nxt;
      res.name_len     = nsize_nxt;
      res.is_trailer   = tseen_nxt;
      res.bad_digit    = bad_nxt;
      res.archive_end  = aend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      len_m1_r <= HEADER_LAST;
      fsize_r  <= '0;
      nsize_r  <= '0;
      tmatch_r <= 1'b1;
      tseen_r  <= 1'b0;
      bad_r    <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      len_m1_r <= len_m1_nxt;
      fsize_r  <= fsize_nxt;
      nsize_r  <= nsize_nxt;
      tmatch_r <= tmatch_nxt;
      tseen_r  <= tseen_nxt;
      bad_r    <= bad_nxt;
    end
  end

endmodule

FILE: src/cpio_newc_stream_parser.sv
// ----------------------------------------------------------------------------
// cpio_newc_stream_parser
// Tags each byte of a newc cpio archive stream with its part and offset.
// ----------------------------------------------------------------------------
// usage
//   input channel: one archive byte per transaction on in_data_byte
//   output channel: exactly one tagged transaction per input byte, in order
//   every byte is passed through on out_data_out with its class (header,
//     name, name pad, data, data pad, after end), offset in its part, the
//     decoded file and name sizes, and trailer/bad digit/end flags
//   path: a byte accepted into the input register is loaded into the
//     result register when the result register can take a new value
//   throughput: one byte per cycle while out_stall is low, set by the
//     state update in cnp_step between the input and result registers
//   reset (rst_n low, synchronous): parser returns to header offset 0,
//     both pipeline registers are emptied, sizes and flags cleared
//   receiver stall: the result register holds; the input register keeps
//     filling, and in_stall rises only when both registers are full and
//     out_stall is high
//   after the trailer entry ends, bytes are tagged as after-end until reset
// ----------------------------------------------------------------------------
module cpio_newc_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_out,
  output logic [2:0]  out_byte_class,
  output logic [32:0] out_part_offset,
  output logic        out_last_of_part,
  output logic        out_entry_start,
  output logic [31:0] out_file_len,
  output logic [31:0] out_name_len,
  output logic        out_is_trailer,
  output logic        out_bad_digit,
  output logic        out_archive_end
);
  import cnp_pkg::*;

  // input register stage
  logic        in_valid_r;
  logic [7:0]  in_byte_r;

  // result register stage
  logic        out_valid_r;
  cnp_result_t res_r;
  cnp_result_t step_res;

  logic        out_free;   // result register can take a new value
  logic        in_free;    // input register can take a new byte
  logic        step_en;    // byte moves from input register through the parser

  assign out_free = !out_valid_r || !out_stall;
  assign in_free  = !in_valid_r || out_free;
  assign step_en  = in_valid_r && out_free;
  assign in_stall = !in_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_free) begin
      in_valid_r <= in_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_free && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

  // parser state and byte classification
  cnp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .byte_in (in_byte_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_en;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_out     = res_r.data_out;
  assign out_byte_class   = res_r.byte_class;
  assign out_part_offset  = res_r.part_offset;
  assign out_last_of_part = res_r.last_of_part;
  assign out_entry_start  = res_r.entry_start;
  assign out_file_len     = res_r.file_len;
  assign out_name_len     = res_r.name_len;
  assign out_is_trailer   = res_r.is_trailer;
  assign out_bad_digit    = res_r.bad_digit;
  assign out_archive_end  = res_r.archive_end;

endmodule

FILE: src/cnp_checker.sv
// ----------------------------------------------------------------------------
// cnp_checker
// Port-level checks for the newc cpio stream parser, bound to the top level.
// ----------------------------------------------------------------------------
module cnp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_data_out,
  input logic [2:0]  out_byte_class,
  input logic [32:0] out_part_offset,
  input logic        out_last_of_part,
  input logic        out_entry_start,
  input logic [31:0] out_file_len,
  input logic        out_archive_end
);
  import cnp_pkg::*;

  // a stalled result transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_out)
      && $stable(out_part_offset))
    else $error("stalled result transaction changed");

  // input side only backs up when a result is waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // archive end only on the final byte of a name or data part
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_archive_end |-> out_last_of_part
      && out_byte_class != CLS_HEADER && out_byte_class != CLS_END)
    else $error("archive end on wrong byte");

  // an entry starts at header offset zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_start |-> out_byte_class == CLS_HEADER
      && out_part_offset == '0 && out_file_len == '0)
    else $error("entry start not at header offset zero");

endmodule

bind cpio_newc_stream_parser cnp_checker u_cnp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_data_out     (out_data_out),
  .out_byte_class   (out_byte_class),
  .out_part_offset  (out_part_offset),
  .out_last_of_part (out_last_of_part),
  .out_entry_start  (out_entry_start),
  .out_file_len     (out_file_len),
  .out_archive_end  (out_archive_end)
);
